FILE: rtl/lwd_pkg.sv
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and constants of the least-wait provider dispatcher.
// ----------------------------------------------------------------------------
package lwd_pkg;

    // Field widths fixed by the channel definitions.
    localparam int TIME_W  = 32;
    localparam int SVC_W   = 24;
    localparam int RND_W   = 8;
    localparam int RISK_W  = 9;
    localparam int MASK_W  = 8;
    localparam int MINW_W  = 16;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 16;

    // Default sizing of the provider pool.
    localparam int NUM_PROVIDERS_DEF      = 8;
    localparam int SLOTS_PER_PROVIDER_DEF = 4;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [RISK_W-1:0] RISK_ONE = 9'd256;

    // Register indexes on the configuration channel.
    localparam logic [CIDX_W-1:0] CFG_RISK_FACTOR  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FLAGGED_MASK = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_WAIT     = 2'd2;

    // Register reset values.
    localparam logic [RISK_W-1:0] RISK_FACTOR_RST  = 9'd256;
    localparam logic [MASK_W-1:0] FLAGGED_MASK_RST = 8'd0;
    localparam logic [MINW_W-1:0] MIN_WAIT_RST     = 16'd17;

    typedef struct packed {
        logic [TIME_W-1:0] now;
        logic [SVC_W-1:0]  service_time;
        logic [RND_W-1:0]  random_pick;
    } t_req;

    typedef struct packed {
        logic [2:0]        provider_index;
        logic [TIME_W-1:0] advertised_wait;
        logic [3:0]        tie_count;
        logic [TIME_W-1:0] provider_free_at;
    } t_res;

    typedef struct packed {
        logic [CIDX_W-1:0]  index;
        logic [CDATA_W-1:0] wdata;
    } t_cfg;

endpackage

FILE: rtl/lwd_stream_if.sv
// ----------------------------------------------------------------------------
// lwd_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface lwd_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/lwd_wait_calc.sv
// ----------------------------------------------------------------------------
// lwd_wait_calc
// Two-stage shared unit computing the advertised wait of one provider a cycle.
// ----------------------------------------------------------------------------
module lwd_wait_calc #(
    parameter int NUM_PROVIDERS = lwd_pkg::NUM_PROVIDERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [((NUM_PROVIDERS > 1) ? $clog2(NUM_PROVIDERS) : 1)-1:0] i_idx,
    input  logic [lwd_pkg::TIME_W-1:0]  i_next_free,
    input  logic [lwd_pkg::TIME_W-1:0]  i_now,
    input  logic                        i_flag,
    input  logic [lwd_pkg::RISK_W-1:0]  i_risk,
    input  logic [lwd_pkg::MINW_W-1:0]  i_min_wait,
    output logic                        o_vld,
    output logic [((NUM_PROVIDERS > 1) ? $clog2(NUM_PROVIDERS) : 1)-1:0] o_idx,
    output logic [lwd_pkg::TIME_W-1:0]  o_wait
);

    localparam int PW = (NUM_PROVIDERS > 1) ? $clog2(NUM_PROVIDERS) : 1;
    localparam int TW = lwd_pkg::TIME_W;
    localparam int RW = lwd_pkg::RISK_W;
    localparam int PRODW = TW + RW;

    logic          r_s1_vld;
    logic [PW-1:0] r_s1_idx;
    logic [TW-1:0] r_diff;
    logic          r_le;
    logic          r_flag;
    logic          r_s2_vld;
    logic [PW-1:0] r_s2_idx;
    logic [TW-1:0] r_wait;

    logic [RW-1:0]    factor;
    logic [PRODW-1:0] prod;
    logic [TW-1:0]    scaled;
    logic [TW-1:0]    min_ext;
    logic [TW-1:0]    n_wait;

    // A risk above one is clamped, which leaves a zero scale factor.
    always_comb begin
        factor  = (i_risk > lwd_pkg::RISK_ONE) ? '0 : lwd_pkg::RISK_ONE - i_risk;
        prod    = {{RW{1'b0}}, r_diff} * {{TW{1'b0}}, factor};
        scaled  = r_flag ? prod[TW+7:8] : r_diff;
        min_ext = {{(TW-lwd_pkg::MINW_W){1'b0}}, i_min_wait};
        n_wait  = (r_le || (scaled < min_ext)) ? min_ext : scaled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_idx;
        r_diff   <= i_next_free - i_now;
        r_le     <= (i_next_free <= i_now);
        r_flag   <= i_flag;
        r_s2_idx <= r_s1_idx;
        r_wait   <= n_wait;
    end

    assign o_vld  = r_s2_vld;
    assign o_idx  = r_s2_idx;
    assign o_wait = r_wait;

endmodule

FILE: rtl/lwd_mod_unit.sv
// ----------------------------------------------------------------------------
// lwd_mod_unit
// Restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module lwd_mod_unit #(
    parameter int NUM_PROVIDERS = lwd_pkg::NUM_PROVIDERS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [lwd_pkg::RND_W-1:0]              i_dividend,
    input  logic [$clog2(NUM_PROVIDERS + 1)-1:0]   i_divisor,
    output logic                                   o_done,
    output logic [$clog2(NUM_PROVIDERS + 1)-1:0]   o_rem
);

    localparam int TW = $clog2(NUM_PROVIDERS + 1);
    localparam int DW = lwd_pkg::RND_W;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST_STEP = CW'(DW - 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dvd;
    logic [TW-1:0] r_rem;

    logic [TW:0]   shifted;
    logic [TW:0]   trial;
    logic [TW-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_dvd[DW-1]};
        trial   = shifted - {1'b0, i_divisor};
        n_rem   = (shifted >= {1'b0, i_divisor}) ? trial[TW-1:0] : shifted[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DW-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

FILE: rtl/lwd_slot_store.sv
// ----------------------------------------------------------------------------
// lwd_slot_store
// Slot free-time memory with a registered read and a zeroing pass after reset.
// ----------------------------------------------------------------------------
module lwd_slot_store #(
    parameter int NUM_PROVIDERS      = lwd_pkg::NUM_PROVIDERS_DEF,
    parameter int SLOTS_PER_PROVIDER = lwd_pkg::SLOTS_PER_PROVIDER_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [$clog2(NUM_PROVIDERS * SLOTS_PER_PROVIDER)-1:0] i_rd_addr,
    output logic [lwd_pkg::TIME_W-1:0] o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(NUM_PROVIDERS * SLOTS_PER_PROVIDER)-1:0] i_wr_addr,
    input  logic [lwd_pkg::TIME_W-1:0] i_wr_data,
    output logic                       o_busy
);

    localparam int DEPTH = NUM_PROVIDERS * SLOTS_PER_PROVIDER;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    logic [lwd_pkg::TIME_W-1:0] mem [DEPTH];
    logic [lwd_pkg::TIME_W-1:0] r_rd_data;
    logic                       r_busy;
    logic [AW-1:0]              r_clr_addr;

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [lwd_pkg::TIME_W-1:0] wr_data;

    // The zeroing pass owns the write port until it has swept every entry.
    always_comb begin
        wr_en   = r_busy | i_wr_en;
        wr_addr = r_busy ? r_clr_addr : i_wr_addr;
        wr_data = r_busy ? '0 : i_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

FILE: rtl/least_wait_provider_dispatcher_core.sv
// ----------------------------------------------------------------------------
// least_wait_provider_dispatcher_core
// Picks the provider with the least advertised wait, breaks ties at random,
// and books the earliest-free slot of the chosen provider.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                       Handshake
//  -------  ---  --------------------------------------------  -----------
//  i_req    in   now, service_time, random_pick                valid/ready
//  o_res    out  provider_index, advertised_wait, tie_count,   valid/ready
//                provider_free_at
//  i_cfg    in   index (risk, mask, min wait), wdata           valid/ready
//
// A request passes in turn through the two-stage wait unit, the bit-serial
// remainder, and a registered read of each slot from the slot memory.
// After reset the slot memory is zeroed; requests wait for it, and
// configuration beats are taken at once. A result beat that is not taken
// stalls only the completion of the following request.
// ----------------------------------------------------------------------------
module least_wait_provider_dispatcher_core #(
    parameter int NUM_PROVIDERS      = lwd_pkg::NUM_PROVIDERS_DEF,
    parameter int SLOTS_PER_PROVIDER = lwd_pkg::SLOTS_PER_PROVIDER_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lwd_stream_if.sink           i_req,
    lwd_stream_if.source         o_res,
    lwd_stream_if.sink           i_cfg
);

    localparam int PW = (NUM_PROVIDERS > 1) ? $clog2(NUM_PROVIDERS) : 1;
    localparam int TW = $clog2(NUM_PROVIDERS + 1);
    localparam int AW = $clog2(NUM_PROVIDERS * SLOTS_PER_PROVIDER);
    localparam int SW = (SLOTS_PER_PROVIDER > 1) ? $clog2(SLOTS_PER_PROVIDER) : 1;
    localparam int TMW = lwd_pkg::TIME_W;

    localparam logic [PW-1:0] LAST_P = PW'(NUM_PROVIDERS - 1);
    localparam logic [SW-1:0] LAST_S = SW'(SLOTS_PER_PROVIDER - 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_PICK = 3'd3;
    localparam logic [2:0] ST_SLOT = 3'd4;
    localparam logic [2:0] ST_UPD  = 3'd5;
    localparam logic [2:0] ST_NEXT = 3'd6;

    // Configuration registers.
    logic [lwd_pkg::RISK_W-1:0] r_risk;
    logic [lwd_pkg::MASK_W-1:0] r_mask;
    logic [lwd_pkg::MINW_W-1:0] r_min_wait;

    // Control state.
    logic [2:0]    r_state,   n_state;
    logic [PW-1:0] r_p,       n_p;
    logic          r_issue,   n_issue;
    logic          r_ph,      n_ph;
    logic [SW-1:0] r_s,       n_s;
    logic          r_out_vld, n_out_vld;

    // Per-provider state, cleared at reset.
    logic [TMW-1:0] r_nf     [NUM_PROVIDERS];
    logic [TMW-1:0] n_nf     [NUM_PROVIDERS];
    logic [TMW-1:0] r_visits [NUM_PROVIDERS];
    logic [TMW-1:0] n_visits [NUM_PROVIDERS];

    // Working payload of the request in flight.
    logic [TMW-1:0]              r_waits [NUM_PROVIDERS];
    logic [TMW-1:0]              n_waits [NUM_PROVIDERS];
    logic [TMW-1:0]              r_now,      n_now;
    logic [lwd_pkg::SVC_W-1:0]   r_svc,      n_svc;
    logic [lwd_pkg::RND_W-1:0]   r_rnd,      n_rnd;
    logic [TMW-1:0]              r_least,    n_least;
    logic [TW-1:0]               r_ties,     n_ties;
    logic [TW-1:0]               r_pick,     n_pick;
    logic [TW-1:0]               r_seen,     n_seen;
    logic [PW-1:0]               r_chosen,   n_chosen;
    logic [AW-1:0]               r_base,     n_base;
    logic [TMW-1:0]              r_min1,     n_min1;
    logic [TMW-1:0]              r_min2,     n_min2;
    logic [AW-1:0]               r_low_addr, n_low_addr;
    logic [TMW-1:0]              r_new,      n_new;
    lwd_pkg::t_res               r_out,      n_out;

    // Wait unit connections.
    logic           wc_in_vld;
    logic           wc_flag;
    logic           wc_out_vld;
    logic [PW-1:0]  wc_out_idx;
    logic [TMW-1:0] wc_out_wait;

    // Remainder unit connections.
    logic          mod_start;
    logic          mod_done;
    logic [TW-1:0] mod_rem;

    // Slot memory connections.
    logic [AW-1:0]  slot_rd_addr;
    logic [TMW-1:0] slot_rd_data;
    logic           slot_wr_en;
    logic [TMW-1:0] slot_wr_data;
    logic           slot_busy;

    // Slot update arithmetic.
    logic [TMW-1:0] upd_start;
    logic [TMW:0]   upd_sum;
    logic [TMW-1:0] next_low;

    logic req_acc;

    // ------------------------------------------------------------------
    // Handshakes and configuration.
    // ------------------------------------------------------------------
    assign i_req.ready = (r_state == ST_IDLE) && !slot_busy;
    assign req_acc     = i_req.valid && i_req.ready;
    assign i_cfg.ready = 1'b1;
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // Configuration is to be written only between requests, so a write never disturbs
    // a request in flight; the block does not enforce this. Indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_risk     <= lwd_pkg::RISK_FACTOR_RST;
            r_mask     <= lwd_pkg::FLAGGED_MASK_RST;
            r_min_wait <= lwd_pkg::MIN_WAIT_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                lwd_pkg::CFG_RISK_FACTOR: begin
                    r_risk <= i_cfg.data.wdata[lwd_pkg::RISK_W-1:0];
                end
                lwd_pkg::CFG_FLAGGED_MASK: begin
                    r_mask <= i_cfg.data.wdata[lwd_pkg::MASK_W-1:0];
                end
                lwd_pkg::CFG_MIN_WAIT: begin
                    r_min_wait <= i_cfg.data.wdata;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared units.
    // ------------------------------------------------------------------

    // Only providers below the mask width can be flagged.
    assign wc_flag = (int'(r_p) < lwd_pkg::MASK_W) && r_mask[3'(r_p)];

    lwd_wait_calc #(
        .NUM_PROVIDERS (NUM_PROVIDERS)
    ) u_wait_calc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (wc_in_vld),
        .i_idx       (r_p),
        .i_next_free (r_nf[r_p]),
        .i_now       (r_now),
        .i_flag      (wc_flag),
        .i_risk      (r_risk),
        .i_min_wait  (r_min_wait),
        .o_vld       (wc_out_vld),
        .o_idx       (wc_out_idx),
        .o_wait      (wc_out_wait)
    );

    lwd_mod_unit #(
        .NUM_PROVIDERS (NUM_PROVIDERS)
    ) u_mod_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (r_rnd),
        .i_divisor  (r_ties),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    assign slot_rd_addr = r_base + AW'(r_s);

    lwd_slot_store #(
        .NUM_PROVIDERS      (NUM_PROVIDERS),
        .SLOTS_PER_PROVIDER (SLOTS_PER_PROVIDER)
    ) u_slot_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (slot_rd_addr),
        .o_rd_data (slot_rd_data),
        .i_wr_en   (slot_wr_en),
        .i_wr_addr (r_low_addr),
        .i_wr_data (slot_wr_data),
        .o_busy    (slot_busy)
    );

    // A slot that is empty or already past restarts at now; otherwise the
    // new booking queues behind it. The sum saturates at the time maximum.
    always_comb begin
        upd_start = ((r_min1 == '0) || (r_min1 < r_now)) ? r_now : r_min1;
        upd_sum   = {1'b0, upd_start} + {{(TMW + 1 - lwd_pkg::SVC_W){1'b0}}, r_svc};
        next_low  = (r_new < r_min2) ? r_new : r_min2;
        if (next_low < r_now) begin
            next_low = r_now;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_issue    = r_issue;
        n_ph       = r_ph;
        n_s        = r_s;
        n_out_vld  = r_out_vld;
        n_nf       = r_nf;
        n_visits   = r_visits;
        n_waits    = r_waits;
        n_now      = r_now;
        n_svc      = r_svc;
        n_rnd      = r_rnd;
        n_least    = r_least;
        n_ties     = r_ties;
        n_pick     = r_pick;
        n_seen     = r_seen;
        n_chosen   = r_chosen;
        n_base     = r_base;
        n_min1     = r_min1;
        n_min2     = r_min2;
        n_low_addr = r_low_addr;
        n_new      = r_new;
        n_out      = r_out;

        wc_in_vld    = 1'b0;
        mod_start    = 1'b0;
        slot_wr_en   = 1'b0;
        slot_wr_data = upd_sum[TMW] ? lwd_pkg::TIME_MAX : upd_sum[TMW-1:0];

        // The result beat leaves as soon as the sink takes it.
        if (r_out_vld && o_res.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (req_acc) begin
                    n_now   = i_req.data.now;
                    n_svc   = i_req.data.service_time;
                    n_rnd   = i_req.data.random_pick;
                    n_p     = '0;
                    n_issue = 1'b1;
                    n_state = ST_WAIT;
                end
            end

            // Feed one provider a cycle into the wait unit and fold each
            // returned wait into the running least value and tie count.
            ST_WAIT: begin
                if (r_issue) begin
                    wc_in_vld = 1'b1;
                    if (r_p == LAST_P) begin
                        n_issue = 1'b0;
                    end else begin
                        n_p = r_p + 1'b1;
                    end
                end
                if (wc_out_vld) begin
                    n_waits[wc_out_idx] = wc_out_wait;
                    if ((wc_out_idx == '0) || (wc_out_wait < r_least)) begin
                        n_least = wc_out_wait;
                        n_ties  = TW'(1);
                    end else if (wc_out_wait == r_least) begin
                        n_ties = r_ties + 1'b1;
                    end
                    if (wc_out_idx == LAST_P) begin
                        mod_start = 1'b1;
                        n_state   = ST_MOD;
                    end
                end
            end

            ST_MOD: begin
                if (mod_done) begin
                    n_pick  = mod_rem;
                    n_p     = '0;
                    n_seen  = '0;
                    n_state = ST_PICK;
                end
            end

            // Walk the providers in order and stop at the tied one whose
            // rank among the ties equals the remainder.
            ST_PICK: begin
                n_p = r_p + 1'b1;
                if (r_waits[r_p] == r_least) begin
                    if (r_seen == r_pick) begin
                        n_chosen = r_p;
                        n_base   = AW'(int'(r_p) * SLOTS_PER_PROVIDER);
                        n_s      = '0;
                        n_ph     = 1'b0;
                        n_state  = ST_SLOT;
                    end else begin
                        n_seen = r_seen + 1'b1;
                    end
                end
            end

            // For each slot the address goes out, then the registered data comes
            // back. Keep the least slot, its address and the second least, so the
            // next-free time needs no re-read.
            ST_SLOT: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_ph = 1'b0;
                    if (r_s == '0) begin
                        n_min1     = slot_rd_data;
                        n_min2     = lwd_pkg::TIME_MAX;
                        n_low_addr = slot_rd_addr;
                    end else if (slot_rd_data < r_min1) begin
                        n_min1     = slot_rd_data;
                        n_min2     = r_min1;
                        n_low_addr = slot_rd_addr;
                    end else if (slot_rd_data < r_min2) begin
                        n_min2 = slot_rd_data;
                    end
                    if (r_s == LAST_S) begin
                        n_state = ST_UPD;
                    end else begin
                        n_s = r_s + 1'b1;
                    end
                end
            end

            ST_UPD: begin
                slot_wr_en = 1'b1;
                n_new      = slot_wr_data;
                n_state    = ST_NEXT;
            end

            // Commit once the output register is free.
            ST_NEXT: begin
                if (!r_out_vld || o_res.ready) begin
                    n_nf[r_chosen]          = next_low;
                    n_visits[r_chosen]      = r_visits[r_chosen] + 1'b1;
                    n_out.provider_index    = 3'(r_chosen);
                    n_out.advertised_wait   = r_least;
                    n_out.tie_count         = 4'(r_ties);
                    n_out.provider_free_at  = next_low;
                    n_out_vld               = 1'b1;
                    n_state                 = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_p       <= '0;
            r_issue   <= 1'b0;
            r_ph      <= 1'b0;
            r_s       <= '0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < NUM_PROVIDERS; i++) begin
                r_nf[i]     <= '0;
                r_visits[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_p       <= n_p;
            r_issue   <= n_issue;
            r_ph      <= n_ph;
            r_s       <= n_s;
            r_out_vld <= n_out_vld;
            r_nf      <= n_nf;
            r_visits  <= n_visits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waits    <= n_waits;
        r_now      <= n_now;
        r_svc      <= n_svc;
        r_rnd      <= n_rnd;
        r_least    <= n_least;
        r_ties     <= n_ties;
        r_pick     <= n_pick;
        r_seen     <= n_seen;
        r_chosen   <= n_chosen;
        r_base     <= n_base;
        r_min1     <= n_min1;
        r_min2     <= n_min2;
        r_low_addr <= n_low_addr;
        r_new      <= n_new;
        r_out      <= n_out;
    end

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the least-wait provider dispatcher. A scoreboard
// model predicts the chosen provider, its advertised wait, the tie count and
// the refreshed next-free time of every request. A directed table runs first
// and is followed by random traffic under several register settings and
// handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int NPROV = lwd_pkg::NUM_PROVIDERS_DEF;
    localparam int NSLOT = lwd_pkg::SLOTS_PER_PROVIDER_DEF;

    // This index is past the register list, so the block must ignore writes to it.
    localparam logic [lwd_pkg::CIDX_W-1:0] CFG_UNMAPPED = 2'd3;

    // Random traffic: number of setting phases and requests in each.
    localparam int N_PHASES      = 8;
    localparam int REQS_PER_PHASE = 125;

    // Cycles to watch for stray results once everything has drained.
    localparam int SETTLE_CYCLES = 80;

    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    // One row of the directed table. A request row uses a, b and c as now,
    // service time and random pick. A register row uses a as the register
    // index and b as the write data. When typed is set, want holds the
    // result written out by hand. Otherwise the scoreboard model predicts it.
    typedef struct {
        t_row_kind     kind;
        logic [31:0]   a;
        logic [23:0]   b;
        logic [7:0]    c;
        bit            typed;
        lwd_pkg::t_res want;
    } t_stim_row;

    localparam int N_DIRECTED = 33;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // Fresh from reset every provider advertises min_wait, all eight tie,
        // and the pick is random_pick modulo 8. The next-free time becomes
        // now, because three slots are still zero.
        '{ROW_REQ, 32'd1000, 24'd5, 8'd3, 1'b1, {3'd3, 32'd17, 4'd8, 32'd1000}},
        // Largest now and service time. The slot sum saturates, and provider
        // 7 is chosen by 255 modulo 8.
        '{ROW_REQ, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'd255, 1'b1,
          {3'd7, 32'd17, 4'd8, 32'hFFFF_FFFF}},
        // Time going back to zero makes the two busy providers advertise
        // long raw waits.
        '{ROW_REQ, 32'd0, 24'd0, 8'd0, 1'b0, '0},
        // Repeated bookings at one instant fill slots and extend busy ones.
        '{ROW_REQ, 32'd2000, 24'd700, 8'd0, 1'b0, '0},
        '{ROW_REQ, 32'd2000, 24'd700, 8'd1, 1'b0, '0},
        '{ROW_REQ, 32'd2000, 24'd700, 8'd2, 1'b0, '0},
        '{ROW_REQ, 32'd2000, 24'd700, 8'd3, 1'b0, '0},
        '{ROW_REQ, 32'd2000, 24'd700, 8'd5, 1'b0, '0},
        '{ROW_REQ, 32'd2000, 24'd700, 8'd7, 1'b0, '0},
        // Half risk on a sparse flag pattern, with no floor on the wait.
        '{ROW_CFG, 32'(lwd_pkg::CFG_RISK_FACTOR),  24'd128,    8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_FLAGGED_MASK), 24'h0000A5, 8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_MIN_WAIT),     24'd0,      8'd0, 1'b0, '0},
        '{ROW_REQ, 32'd2100, 24'd300, 8'd4, 1'b0, '0},
        '{ROW_REQ, 32'd2100, 24'd300, 8'd9, 1'b0, '0},
        '{ROW_REQ, 32'd2150, 24'd0, 8'd200, 1'b0, '0},
        '{ROW_REQ, 32'd2200, 24'hFF_FFFF, 8'd77, 1'b0, '0},
        // A risk above one is clamped, and the floor is at its top.
        '{ROW_CFG, 32'(lwd_pkg::CFG_RISK_FACTOR), 24'd300,    8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_MIN_WAIT),    24'h00FFFF, 8'd0, 1'b0, '0},
        '{ROW_REQ, 32'd2300, 24'd1, 8'hAA, 1'b0, '0},
        '{ROW_REQ, 32'd2300, 24'd2, 8'h55, 1'b0, '0},
        // A write past the register list must change nothing.
        '{ROW_CFG, 32'(CFG_UNMAPPED),              24'h00FFFF, 8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_RISK_FACTOR),  24'd0,      8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_FLAGGED_MASK), 24'h0000FF, 8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_MIN_WAIT),     24'd0,      8'd0, 1'b0, '0},
        '{ROW_REQ, 32'd2400, 24'd1000, 8'd128, 1'b0, '0},
        '{ROW_REQ, 32'd2400, 24'd1000, 8'd255, 1'b0, '0},
        '{ROW_REQ, 32'd2500, 24'd0, 8'd0, 1'b0, '0},
        // All nine risk bits set, which is clamped as well.
        '{ROW_CFG, 32'(lwd_pkg::CFG_RISK_FACTOR),  24'h0001FF, 8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_FLAGGED_MASK), 24'h00000F, 8'd0, 1'b0, '0},
        '{ROW_CFG, 32'(lwd_pkg::CFG_MIN_WAIT),     24'd17,     8'd0, 1'b0, '0},
        // Near the top of time the extend path saturates too.
        '{ROW_REQ, 32'hFFFF_FF00, 24'hFF_FFFF, 8'd1, 1'b0, '0},
        '{ROW_REQ, 32'hFFFF_FFFF, 24'd0, 8'd254, 1'b0, '0},
        '{ROW_REQ, 32'd0, 24'hFF_FFFF, 8'd128, 1'b0, '0}
    };

    // ------------------------------------------------------------------------
    // Clock, reset and channels.
    // ------------------------------------------------------------------------
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    lwd_stream_if #(.t_payload(lwd_pkg::t_req)) req_if ();
    lwd_stream_if #(.t_payload(lwd_pkg::t_res)) res_if ();
    lwd_stream_if #(.t_payload(lwd_pkg::t_cfg)) cfg_if ();

    least_wait_provider_dispatcher_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // ------------------------------------------------------------------------
    // Scoreboard model. It holds its own copy of the registers and of every
    // store, all starting from their reset values. Reset is applied only once,
    // so the declarations give the starting values.
    // ------------------------------------------------------------------------
    logic [lwd_pkg::RISK_W-1:0] risk_reg     = lwd_pkg::RISK_FACTOR_RST;
    logic [lwd_pkg::MASK_W-1:0] mask_reg     = lwd_pkg::FLAGGED_MASK_RST;
    logic [lwd_pkg::MINW_W-1:0] min_wait_reg = lwd_pkg::MIN_WAIT_RST;

    logic [lwd_pkg::TIME_W-1:0] slot_busy_until [NPROV*NSLOT] = '{default: '0};
    logic [lwd_pkg::TIME_W-1:0] prov_free_at    [NPROV]       = '{default: '0};
    logic [31:0]                prov_visits     [NPROV]       = '{default: '0};

    // Results still owed by the block, oldest first.
    lwd_pkg::t_res pending_dispatch [$];

    int requests_sent   = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int mismatches      = 0;

    // Handshake idling, in percent of cycles.
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // This is the wait that provider p advertises at time now. A provider that
    // is already free advertises the floor. A flagged one scales its backlog
    // by one minus the clamped risk, truncating the fraction.
    function automatic logic [lwd_pkg::TIME_W-1:0] wait_for(
        input int unsigned                p,
        input logic [lwd_pkg::TIME_W-1:0] now);
        logic [lwd_pkg::TIME_W-1:0] gap;
        logic [lwd_pkg::TIME_W-1:0] floor_w;
        logic [lwd_pkg::RISK_W-1:0] keep;
        logic [40:0]                scaled;
        floor_w = {16'd0, min_wait_reg};
        if (prov_free_at[p] <= now) begin
            return floor_w;
        end
        gap = prov_free_at[p] - now;
        if (p < lwd_pkg::MASK_W && mask_reg[p]) begin
            keep   = lwd_pkg::RISK_ONE -
                     ((risk_reg > lwd_pkg::RISK_ONE) ? lwd_pkg::RISK_ONE : risk_reg);
            scaled = gap * keep;
            gap    = scaled[39:8];
        end
        return (gap < floor_w) ? floor_w : gap;
    endfunction

    // This works out the result of one request and applies its booking to
    // the model's stores.
    function automatic lwd_pkg::t_res dispatch_expect(input lwd_pkg::t_req r);
        logic [lwd_pkg::TIME_W-1:0] waits [NPROV];
        logic [lwd_pkg::TIME_W-1:0] least;
        logic [lwd_pkg::TIME_W-1:0] booked;
        logic [lwd_pkg::TIME_W-1:0] low;
        logic [lwd_pkg::TIME_W:0]   sum;
        int unsigned                ties;
        int unsigned                pick;
        int unsigned                seen;
        int unsigned                chosen;
        int unsigned                base;
        int unsigned                low_slot;
        lwd_pkg::t_res              res;

        for (int unsigned p = 0; p < NPROV; p++) begin
            waits[p] = wait_for(p, r.now);
        end
        least = waits[0];
        for (int unsigned p = 1; p < NPROV; p++) begin
            if (waits[p] < least) begin
                least = waits[p];
            end
        end
        ties = 0;
        for (int unsigned p = 0; p < NPROV; p++) begin
            if (waits[p] == least) begin
                ties++;
            end
        end

        // The tie break counts the tied providers in ascending order.
        pick   = r.random_pick % ties;
        seen   = 0;
        chosen = 0;
        for (int unsigned p = 0; p < NPROV; p++) begin
            if (waits[p] == least) begin
                if (seen == pick) begin
                    chosen = p;
                    break;
                end
                seen++;
            end
        end

        // The earliest-free slot takes the booking, and the lowest index wins
        // an equal value. An empty or lapsed slot starts at now. A busy slot
        // is extended.
        base     = chosen * NSLOT;
        low_slot = 0;
        for (int unsigned s = 1; s < NSLOT; s++) begin
            if (slot_busy_until[base + s] < slot_busy_until[base + low_slot]) begin
                low_slot = s;
            end
        end
        booked = slot_busy_until[base + low_slot];
        if (booked == '0 || booked < r.now) begin
            sum = {1'b0, r.now} + r.service_time;
        end else begin
            sum = {1'b0, booked} + r.service_time;
        end
        slot_busy_until[base + low_slot] =
            sum[lwd_pkg::TIME_W] ? lwd_pkg::TIME_MAX : sum[lwd_pkg::TIME_W-1:0];

        low = slot_busy_until[base];
        for (int unsigned s = 1; s < NSLOT; s++) begin
            if (slot_busy_until[base + s] < low) begin
                low = slot_busy_until[base + s];
            end
        end
        if (low < r.now) begin
            low = r.now;
        end
        prov_free_at[chosen] = low;
        prov_visits[chosen]  = prov_visits[chosen] + 1;

        res.provider_index   = chosen[2:0];
        res.advertised_wait  = least;
        res.tie_count        = ties[3:0];
        res.provider_free_at = low;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on result %0d, %s: got 0x%0h, expected 0x%0h",
                 $realtime, results_checked, what, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driving. Each sending task returns on the clock edge that accepted its beat and
    // leaves valid high. Whatever runs next sets valid in that same time step,
    // either high with a new beat or low. This avoids a lower-then-raise pair
    // of assignments in a single step.
    // ------------------------------------------------------------------------
    task automatic push_request(input lwd_pkg::t_req r, input bit typed,
                                input lwd_pkg::t_res typed_res);
        lwd_pkg::t_res predicted;
        // The configuration channel stays quiet while requests flow.
        cfg_if.valid <= 1'b0;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < tx_idle_pct);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        // The beat is accepted here. The model advances even for a row whose
        // result is typed into the table, so that later rows stay in step.
        predicted = dispatch_expect(r);
        pending_dispatch.push_back(typed ? typed_res : predicted);
        requests_sent++;
    endtask

    task automatic write_register(input logic [lwd_pkg::CIDX_W-1:0] idx,
                                  input logic [lwd_pkg::CDATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= {idx, value};
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            lwd_pkg::CFG_RISK_FACTOR:  risk_reg     = value[lwd_pkg::RISK_W-1:0];
            lwd_pkg::CFG_FLAGGED_MASK: mask_reg     = value[lwd_pkg::MASK_W-1:0];
            lwd_pkg::CFG_MIN_WAIT:     min_wait_reg = value[lwd_pkg::MINW_W-1:0];
            default:                   ;
        endcase
        cfg_writes++;
    endtask

    // This lowers both request-side valids and waits until every owed result
    // has been taken. Every request yields a result, so the block is idle at
    // that point. The loop waits for a clock edge before it checks, so this task
    // never sets valid twice in one step.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        cfg_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_dispatch.size() != 0);
    endtask

    // ------------------------------------------------------------------------
    // Result side. The receiver stalls at random according to rx_stall_pct.
    // Each accepted beat is checked field by field against the oldest
    // expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin : result_check
        lwd_pkg::t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_dispatch.size() == 0) begin
                report_mismatch("beat with no request outstanding",
                                32'(res_if.data.provider_index), '0);
            end else begin
                want = pending_dispatch.pop_front();
                if (res_if.data.provider_index !== want.provider_index) begin
                    report_mismatch("provider_index", 32'(res_if.data.provider_index),
                                    32'(want.provider_index));
                end
                if (res_if.data.advertised_wait !== want.advertised_wait) begin
                    report_mismatch("advertised_wait", res_if.data.advertised_wait,
                                    want.advertised_wait);
                end
                if (res_if.data.tie_count !== want.tie_count) begin
                    report_mismatch("tie_count", 32'(res_if.data.tie_count),
                                    32'(want.tie_count));
                end
                if (res_if.data.provider_free_at !== want.provider_free_at) begin
                    report_mismatch("provider_free_at", res_if.data.provider_free_at,
                                    want.provider_free_at);
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        logic [lwd_pkg::TIME_W-1:0] clock_now;
        lwd_pkg::t_req              rq;
        int                         sel;
        bit                         prev_was_cfg;

        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed table runs with no idling. Register rows come only
        // after the block has drained, and a run of them follows back to back.
        prev_was_cfg = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                if (!prev_was_cfg) begin
                    wait_drained();
                end
                write_register(directed_rows[i].a[lwd_pkg::CIDX_W-1:0],
                               directed_rows[i].b[lwd_pkg::CDATA_W-1:0]);
                prev_was_cfg = 1'b1;
            end else begin
                rq.now          = directed_rows[i].a;
                rq.service_time = directed_rows[i].b;
                rq.random_pick  = directed_rows[i].c;
                push_request(rq, directed_rows[i].typed, directed_rows[i].want);
                prev_was_cfg = 1'b0;
            end
        end

        // Random traffic. Each phase drains the block, picks an idling pattern
        // and a register setting, and then issues a run of requests. Time
        // mostly moves forward in small steps against small service times, so
        // that backlogs build up and waits compete. A minority of requests
        // jump time anywhere, step back, sit near the top of the range or
        // carry a full-width service time.
        clock_now = 32'd3000;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 86; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 86; end
                default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
            endcase

            case (ph % 4)
                0: write_register(lwd_pkg::CFG_RISK_FACTOR, 16'd0);
                1: write_register(lwd_pkg::CFG_RISK_FACTOR, 16'd256);
                2: write_register(lwd_pkg::CFG_RISK_FACTOR,
                                  16'($urandom_range(1, 255)));
                default: write_register(lwd_pkg::CFG_RISK_FACTOR,
                                        16'($urandom_range(257, 511)));
            endcase
            case (ph % 3)
                0: write_register(lwd_pkg::CFG_FLAGGED_MASK, 16'h00FF);
                1: write_register(lwd_pkg::CFG_FLAGGED_MASK, 16'h0000);
                default: write_register(lwd_pkg::CFG_FLAGGED_MASK,
                                        16'($urandom_range(0, 255)));
            endcase
            case ((ph + 1) % 4)
                0: write_register(lwd_pkg::CFG_MIN_WAIT, 16'd0);
                1: write_register(lwd_pkg::CFG_MIN_WAIT, 16'hFFFF);
                2: write_register(lwd_pkg::CFG_MIN_WAIT, 16'($urandom_range(0, 65535)));
                default: write_register(lwd_pkg::CFG_MIN_WAIT, 16'($urandom_range(0, 50)));
            endcase
            if (ph % 2 == 1) begin
                write_register(CFG_UNMAPPED, 16'($urandom_range(0, 65535)));
            end

            repeat (REQS_PER_PHASE) begin
                sel = $urandom_range(0, 99);
                rq.service_time = 24'($urandom_range(0, 4000));
                if (sel < 80) begin
                    clock_now = clock_now + $urandom_range(0, 400);
                end else if (sel < 88) begin
                    clock_now       = clock_now + $urandom_range(0, 400);
                    rq.service_time = 24'($urandom);
                end else if (sel < 93) begin
                    clock_now = $urandom;
                end else if (sel < 97) begin
                    clock_now = clock_now - $urandom_range(0, 5000);
                end else begin
                    clock_now       = lwd_pkg::TIME_MAX - $urandom_range(0, 20000);
                    rq.service_time = 24'($urandom_range(0, 30000));
                end
                rq.now         = clock_now;
                rq.random_pick = 8'($urandom_range(0, 255));
                push_request(rq, 1'b0, '0);
            end
        end

        // Let everything owed come back, then keep watching for a while for
        // beats nobody asked for.
        wait_drained();
        rx_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (pending_dispatch.size() != 0) begin
            report_mismatch("results never delivered", 32'(pending_dispatch.size()), '0);
        end

        $display("Covered %0d dispatch requests (%0d directed rows) and %0d register writes,",
                 requests_sent, N_DIRECTED, cfg_writes);
        $display("under four idling patterns; %0d results checked, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // This limit leaves a wide margin over the slowest correct run.
    initial begin
        #4_000_000;
        $display("Timeout with %0d results outstanding.", pending_dispatch.size());
        $display("FAILURE");
        $finish;
    end

endmodule
